@@ sv/fpa_pkg.sv @@
// Package with shared types, constants and commands for the fixed-point ALU.
package fpa_pkg;
    localparam int INT_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int W             = INT_BITS_DEF + FRAC_BITS_DEF;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic signed [W-1:0] result;
        logic                div_by_zero;
        logic                overflow;
    } out_beat_t;
endpackage

@@ sv/fpa_div_stage.sv @@
// One restoring-division step: shift in a dividend bit, compare, subtract.
module fpa_div_stage #(
    parameter int DW = 40
) (
    input  logic [DW:0]   rem_in,
    input  logic          bit_in,
    input  logic [DW-1:0] divisor,
    output logic [DW:0]   rem_out,
    output logic          q_bit
);
    logic [DW+1:0] trial;

    always_comb
    begin
        trial   = {rem_in, bit_in} - {2'b00, divisor};
        q_bit   = ~trial[DW+1];
        rem_out = q_bit ? trial[DW:0] : {rem_in[DW-1:0], bit_in};
    end
endmodule

@@ sv/fixed_point_alu_q32_8_top.sv @@
// Top level of the pipelined Q32.8 fixed-point ALU.
//   Channel | Ports                       | Handshake
//   input   | start, busy, in_beat        | taken when start and not busy
//   output  | done, out_beat              | one-cycle strobe, no back pressure
// The stages are the input register, multiply and sign, 12 divider stages and the output.
// The divider runs four restoring steps per stage and sets the depth; one beat per cycle.
// Reset clears all valid bits; busy is always low.
// The receiver cannot stall, so nothing ever holds the pipeline.
module fixed_point_alu_q32_8_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fpa_pkg::in_beat_t in_beat,
    output logic              done,
    output fpa_pkg::out_beat_t out_beat
);
    localparam int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF;
    localparam int W     = fpa_pkg::W;
    localparam int N     = W + FRAC_BITS;
    localparam int SPS   = 4;
    localparam int NST   = (N + SPS - 1) / SPS;
    localparam int NP    = NST * SPS;
    localparam int PW    = 2 * W;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [W-1:0] sum;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic         neg;
    } s1_t;

    s1_t s1_reg, s1_next;
    logic v1_reg;

    logic [W-1:0] a_u, b_u;
    always_comb
    begin
        a_u = in_beat.operand_a;
        b_u = in_beat.operand_b;
        s1_next.cmd = in_beat.cmd;
        s1_next.sum = (in_beat.cmd == fpa_pkg::CMD_SUB) ? a_u - b_u : a_u + b_u;
        s1_next.ma  = a_u[W-1] ? (~a_u + 1'b1) : a_u;
        s1_next.mb  = b_u[W-1] ? (~b_u + 1'b1) : b_u;
        s1_next.neg = (a_u[W-1] ^ b_u[W-1]) && (a_u != '0) && (b_u != '0);
    end

    // Multiply in two halves over two stages.
    localparam int HW = W / 2;
    logic [W+HW-1:0] plo_reg, phi_reg;
    always_ff @(posedge clk)
    begin
        plo_reg <= s1_next.ma * s1_next.mb[HW-1:0];
        phi_reg <= s1_next.ma * s1_next.mb[W-1:HW];
    end

    logic [PW-1:0] prod;
    assign prod = {{(PW-W-HW){1'b0}}, plo_reg} + {phi_reg, {HW{1'b0}}};

    typedef struct packed {
        logic [1:0]   cmd;
        logic [W-1:0] val;
        logic         ovf;
        logic         dz;
        logic         neg;
        logic [N-1:0] dvd;
        logic [W:0]   rem;
        logic [NP-1:0] q;
        logic [W-1:0] mb;
    } sp_t;

    sp_t sp_reg [0:NST];
    logic [NST:0] vp_reg;

    logic [PW-1:0] psh;
    logic [W-1:0]  mlim;
    sp_t           s2_next;
    always_comb
    begin
        psh  = prod >> FRAC_BITS;
        mlim = s1_reg.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        s2_next     = '0;
        s2_next.cmd = s1_reg.cmd;
        s2_next.neg = s1_reg.neg;
        s2_next.mb  = s1_reg.mb;
        s2_next.dvd = {s1_reg.ma, {FRAC_BITS{1'b0}}};
        s2_next.dz  = (s1_reg.cmd == fpa_pkg::CMD_DIV) && (s1_reg.mb == '0);
        case (s1_reg.cmd)
            fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB: s2_next.val = s1_reg.sum;
            fpa_pkg::CMD_MUL:
            begin
                if ((psh[PW-1:W] != '0) || (psh[W-1:0] > mlim))
                begin
                    s2_next.ovf = 1'b1;
                    s2_next.val = mlim;
                end
                else
                begin
                    s2_next.val = psh[W-1:0];
                end
                if (s2_next.val != '0 && s1_reg.neg)
                    s2_next.val = ~s2_next.val + 1'b1;
            end
            default: s2_next.val = '0;
        endcase
    end

    genvar g, k;
    generate
        for (g = 0; g < NST; g++)
        begin : g_div
            logic [W:0] r [0:SPS];
            logic [SPS-1:0] qb;
            sp_t nx;
            assign r[0] = sp_reg[g].rem;
            for (k = 0; k < SPS; k++)
            begin : g_step
                localparam int IDX = N - 1 - (g * SPS + k);
                logic bi;
                if (IDX >= 0)
                begin : g_b
                    assign bi = sp_reg[g].dvd[IDX];
                end
                else
                begin : g_z
                    assign bi = 1'b0;
                end
                fpa_div_stage #(.DW(W)) u_st (
                    .rem_in (r[k]),
                    .bit_in (bi),
                    .divisor(sp_reg[g].mb),
                    .rem_out(r[k+1]),
                    .q_bit  (qb[SPS-1-k])
                );
            end
            always_comb
            begin
                nx     = sp_reg[g];
                nx.rem = r[SPS];
                nx.q   = {sp_reg[g].q[NP-SPS-1:0], qb};
            end
            always_ff @(posedge clk)
            begin
                sp_reg[g+1] <= nx;
            end
        end
    endgenerate

    // Padding steps past the last dividend bit add extra low quotient bits.
    localparam int PADB = NP - N;
    logic [N-1:0] qf;
    logic [W-1:0] dlim, dval;
    logic         dovf;
    sp_t          sl;
    assign sl = sp_reg[NST];
    assign qf = sl.q[NP-1:PADB];
    always_comb
    begin
        dlim = sl.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        dovf = (qf[N-1:W] != '0) || (qf[W-1:0] > dlim);
        dval = dovf ? dlim : qf[W-1:0];
        if (sl.neg && dval != '0)
            dval = ~dval + 1'b1;
    end

    fpa_pkg::out_beat_t out_next;
    always_comb
    begin
        out_next.div_by_zero = sl.dz;
        if (sl.cmd == fpa_pkg::CMD_DIV)
        begin
            out_next.result   = sl.dz ? '0 : dval;
            out_next.overflow = !sl.dz && dovf;
        end
        else
        begin
            out_next.result   = sl.val;
            out_next.overflow = sl.ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        sp_reg[0] <= s2_next;
        out_beat  <= out_next;
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            vp_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            vp_reg   <= {vp_reg[NST-1:0], v1_reg};
            done_reg <= vp_reg[NST];
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(NST+3) done)
        else $error("beat lost in pipeline");
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_beat.div_by_zero |-> out_beat.result == '0 && !out_beat.overflow)
        else $error("divide by zero result not clean");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(NST+3) !done)
        else $error("spurious result");
endmodule

@@ test/tb_fixed_point_alu_q32_8_top.sv @@
// Self-checking testbench for the Q32.8 fixed-point ALU: predicts each result and compares it.
`timescale 1ns / 100ps

module tb_fixed_point_alu_q32_8_top;
    localparam int W  = fpa_pkg::W;
    localparam int FB = fpa_pkg::FRAC_BITS_DEF;
    localparam int LAT = 14;
    localparam longint CYCLE_LIMIT = 200000;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    fpa_pkg::in_beat_t  in_beat;
    logic               done;
    fpa_pkg::out_beat_t out_beat;

    fpa_pkg::out_beat_t alu_expected[$];
    int        err_count;
    longint    cycle_count;
    bit        no_idle;

    fixed_point_alu_q32_8_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .in_beat  (in_beat),
        .done     (done),
        .out_beat (out_beat)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [W-1:0] abs_val(logic [W-1:0] x);
        return x[W-1] ? -x : x;
    endfunction

    function automatic logic [W-1:0] apply_sign(logic [W-1:0] mag, bit neg, bit big,
                                                ref bit ovf);
        logic [W-1:0] lim;
        lim = neg ? MOST_NEG : MOST_POS;
        if (big || mag > lim)
        begin
            ovf = 1'b1;
            mag = lim;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic fpa_pkg::out_beat_t alu_predict(fpa_pkg::in_beat_t b);
        fpa_pkg::out_beat_t r;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [2*W-1:0] prod;
        logic [W+FB-1:0] num;
        logic [W+FB-1:0] quo;
        bit neg;
        bit ovf;
        r = '0;
        ovf = 1'b0;
        ma = abs_val(b.operand_a);
        mb = abs_val(b.operand_b);
        neg = (b.operand_a[W-1] != b.operand_b[W-1]) && ma != 0 && mb != 0;
        case (fpa_pkg::cmd_t'(b.cmd))
            fpa_pkg::CMD_ADD: r.result = b.operand_a + b.operand_b;
            fpa_pkg::CMD_SUB: r.result = b.operand_a - b.operand_b;
            fpa_pkg::CMD_MUL:
            begin
                prod = ({{W{1'b0}}, ma} * {{W{1'b0}}, mb}) >> FB;
                if (prod != 0)
                    r.result = apply_sign(prod[W-1:0], neg, |prod[2*W-1:W], ovf);
            end
            default:
            begin
                if (mb == 0)
                    r.div_by_zero = 1'b1;
                else
                begin
                    num = {ma, {FB{1'b0}}};
                    quo = num / {{FB{1'b0}}, mb};
                    if (quo != 0)
                        r.result = apply_sign(quo[W-1:0], neg, |quo[W+FB-1:W], ovf);
                end
            end
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [W-1:0] rand_operand();
        logic [W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = MOST_NEG;
            1: v = MOST_POS;
            2: v = $urandom_range(0, 1) ? '0 : '1;
            3: v = W'($signed($urandom_range(0, 2047)) - 1024);
            4: v = W'($signed({$urandom(), 8'h00})) >>> $urandom_range(0, 30);
            default: v = W'({$urandom(), $urandom()});
        endcase
        return v;
    endfunction

    task automatic send_beat(logic [1:0] c, logic [W-1:0] a, logic [W-1:0] b);
        fpa_pkg::in_beat_t item;
        item.cmd = c;
        item.operand_a = a;
        item.operand_b = b;
        while (!no_idle && $urandom_range(0, 99) < 32)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_beat <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        alu_expected.push_back(alu_predict(item));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (alu_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [W-1:0] vals[6];
        vals = '{MOST_NEG, MOST_POS, '0, W'(1), '1, W'(40'h100)};
        for (int c = 0; c < 4; c++)
        begin
            send_beat(2'(c), vals[0], vals[0]);
            send_beat(2'(c), vals[1], vals[1]);
            send_beat(2'(c), vals[1], vals[4]);
            send_beat(2'(c), vals[0], vals[4]);
            send_beat(2'(c), vals[5], vals[2]);
        end
        send_beat(fpa_pkg::CMD_DIV, vals[3], vals[1]);
        send_beat(fpa_pkg::CMD_MUL, vals[3], vals[3]);
        send_beat(fpa_pkg::CMD_DIV, vals[2], vals[4]);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_beat(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
    endtask

    task automatic test_back_to_back(int n);
        no_idle = 1'b1;
        test_random(n);
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    always @(posedge clk)
    begin
        fpa_pkg::out_beat_t exp_beat;
        if (rst_n && done)
        begin
            if (alu_expected.size() == 0)
            begin
                $error("unexpected result beat %h", out_beat);
                err_count++;
            end
            else
            begin
                exp_beat = alu_expected.pop_front();
                if (out_beat.result !== exp_beat.result)
                begin
                    $error("result: expected %h, actual %h", exp_beat.result, out_beat.result);
                    err_count++;
                end
                if (out_beat.div_by_zero !== exp_beat.div_by_zero)
                begin
                    $error("div_by_zero: expected %b, actual %b",
                           exp_beat.div_by_zero, out_beat.div_by_zero);
                    err_count++;
                end
                if (out_beat.overflow !== exp_beat.overflow)
                begin
                    $error("overflow: expected %b, actual %b",
                           exp_beat.overflow, out_beat.overflow);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        err_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        in_beat = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        test_back_to_back(150);
        test_drain_pause();
        test_random(250);
        wait_drained();
        repeat (LAT + 5) @(posedge clk);
        if (err_count == 0 && alu_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
